[rtl/ps2kt_pkg.sv]
// Shared types and constants for the PS/2 keyboard transmitter.
package ps2kt_pkg;

  typedef logic [7:0] byte_t;

  // request kinds carried in s_tuser
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_PRESS   = 3'd1;
  localparam logic [2:0] REQ_RELEASE = 3'd2;
  localparam logic [2:0] REQ_WRITE   = 3'd3;
  localparam logic [2:0] REQ_READ    = 3'd4;

  // link modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_SEND = 2'd1;
  localparam logic [1:0] MODE_REST = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_IRQ_EN = 1'b0;
  localparam logic REG_HALF   = 1'b1;

  localparam byte_t       RELEASE_MARK    = 8'hF0;
  localparam logic [15:0] HALF_RESET      = 16'd20;
  localparam logic [3:0]  LAST_FRAME_SLOT = 4'd10;
  localparam logic [3:0]  PARITY_SLOT     = 4'd8;
  localparam logic [3:0]  STOP_SLOT       = 4'd9;

endpackage

[rtl/ps2_keyboard_transmitter.sv]
// PS/2 keyboard device transmitter: scan code byte ring, frame sender, host control.
// Results: each result is registered (output register, or skid stage under stall);
//   a press or release that queues 1 to 3 bytes gives its result with its last push.
// Throughput: one request per cycle with no bytes pending and the skid stage empty;
//   a multi-byte press or release holds input, as the byte ring has one write port.
// Reset (synchronous, rst high): pointers, link mode and counters cleared, both lines
//   high, host control 3, registers to defaults; ring contents are not cleared.
module ps2_keyboard_transmitter
  import ps2kt_pkg::*;
#(
  parameter int RING_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // scan_code[15:0], host_value[17:16], zero pad
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // read_value[1:0], flag_line[2], irq_pulse[3],
                                 // clock_level[4], data_level[5], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  // configuration
  logic        irq_en;
  logic [15:0] half_ticks;

  // link state
  logic [PTR_W-1:0]   head, head_next, tail, tail_next, push_nxt;
  logic [1:0]         mode, mode_next;
  byte_t              shift_byte, shift_byte_next;
  logic [3:0]         bit_index, bit_index_next;
  logic signed [16:0] tick_count, tick_count_next, half_s;
  logic               parity, parity_next;
  logic [1:0]         lines, lines_next;
  logic [1:0]         host_ctrl, host_ctrl_next;
  logic               irq_next;

  // multi-byte push sequencing
  logic [1:0] pend_cnt, pend_cnt_next;
  byte_t      pend_b0, pend_b0_next, pend_b1, pend_b1_next;
  logic       pend_tick, pend_tick_next;

  // request decode
  logic        accept;
  logic [2:0]  req;
  logic [15:0] scan;
  logic [1:0]  hv;
  byte_t       list0, list1, list2;
  logic [1:0]  list_n;
  logic        do_push, do_tick, do_hw, produce, push_ok;
  byte_t       push_byte, ring_q, pop_byte;

  // output buffer
  logic       skid_valid;
  logic [5:0] out_data, skid_data, res_data;
  logic       out_pop;

  assign req    = s_tuser;
  assign scan   = s_tdata[15:0];
  assign hv     = s_tdata[17:16];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_en     <= 1'b0;
      half_ticks <= HALF_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_IRQ_EN: irq_en     <= pwdata[0];
        REG_HALF:   half_ticks <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IRQ_EN: prdata = {31'd0, irq_en};
      REG_HALF:   prdata = {16'd0, half_ticks};
      default:    prdata = 32'd0;
    endcase
  end

  assign s_tready = (pend_cnt == 2'd0) && !skid_valid;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (scan[15:8] != 8'd0) begin
      list0  = scan[15:8];
      list1  = (req == REQ_RELEASE) ? RELEASE_MARK : scan[7:0];
      list2  = scan[7:0];
      list_n = (req == REQ_RELEASE) ? 2'd3 : 2'd2;
    end else begin
      list0  = (req == REQ_RELEASE) ? RELEASE_MARK : scan[7:0];
      list1  = scan[7:0];
      list2  = scan[7:0];
      list_n = (req == REQ_RELEASE) ? 2'd2 : 2'd1;
    end
  end

  always_comb begin
    do_push        = 1'b0;
    do_tick        = 1'b0;
    do_hw          = 1'b0;
    produce        = 1'b0;
    push_byte      = list0;
    pend_cnt_next  = pend_cnt;
    pend_b0_next   = pend_b0;
    pend_b1_next   = pend_b1;
    pend_tick_next = pend_tick;
    if (pend_cnt != 2'd0) begin
      do_push       = 1'b1;
      push_byte     = pend_b0;
      pend_b0_next  = pend_b1;
      pend_cnt_next = pend_cnt - 2'd1;
      if (pend_cnt == 2'd1) begin
        produce = 1'b1;
        do_tick = pend_tick;
      end
    end else if (accept) begin
      produce = 1'b1;
      case (req)
        REQ_TICK: do_tick = 1'b1;
        REQ_PRESS, REQ_RELEASE: begin
          do_push = 1'b1;
          if (list_n == 2'd1) begin
            do_tick = (req == REQ_PRESS);
          end else begin
            produce        = 1'b0;
            pend_cnt_next  = list_n - 2'd1;
            pend_b0_next   = list1;
            pend_b1_next   = list2;
            pend_tick_next = (req == REQ_PRESS);
          end
        end
        REQ_WRITE: do_hw = 1'b1;
        default: ;
      endcase
    end
  end

  // push with full check
  assign push_nxt = (tail == PTR_LAST) ? '0 : tail + 1'b1;
  assign push_ok  = do_push && (push_nxt != head);
  assign tail_next = push_ok ? push_nxt : tail;
  assign pop_byte  = (push_ok && (tail == head)) ? push_byte : ring_q;
  assign half_s    = $signed({1'b0, half_ticks});

  always_comb begin
    head_next       = head;
    mode_next       = mode;
    shift_byte_next = shift_byte;
    bit_index_next  = bit_index;
    tick_count_next = tick_count;
    parity_next     = parity;
    lines_next      = lines;
    host_ctrl_next  = host_ctrl;
    irq_next        = 1'b0;
    if (do_tick) begin
      if ((mode == MODE_IDLE) && host_ctrl[1] && (head != tail_next)) begin
        shift_byte_next = pop_byte;
        head_next       = (head == PTR_LAST) ? '0 : head + 1'b1;
        mode_next       = MODE_SEND;
        tick_count_next = half_s;
        bit_index_next  = 4'd0;
        lines_next      = 2'b10;
        parity_next     = 1'b1;
      end
      if (mode_next == MODE_SEND) begin
        tick_count_next = tick_count_next - 17'sd1;
        if (tick_count_next <= 17'sd0) begin
          lines_next[1]   = ~lines_next[1];
          irq_next        = irq_en && !lines_next[1];
          tick_count_next = half_s;
          if (lines_next[1]) begin
            lines_next[0] = 1'b0;
            if (bit_index_next < PARITY_SLOT) begin
              parity_next     = parity_next ^ shift_byte_next[0];
              lines_next[0]   = shift_byte_next[0];
              shift_byte_next = {1'b0, shift_byte_next[7:1]};
            end else if (bit_index_next == PARITY_SLOT) begin
              lines_next[0] = parity_next;
            end else if (bit_index_next == STOP_SLOT) begin
              lines_next[0] = 1'b1;
            end else begin
              mode_next       = MODE_REST;
              tick_count_next = half_s;
              lines_next      = 2'b11;
            end
            if (bit_index_next <= LAST_FRAME_SLOT) begin
              bit_index_next = bit_index_next + 4'd1;
            end
          end
        end
      end
      if (mode_next == MODE_REST) begin
        tick_count_next = tick_count_next - 17'sd1;
        if (tick_count_next < 17'sd0) begin
          mode_next = MODE_IDLE;
        end
      end
    end
    if (do_hw) begin
      host_ctrl_next = hv;
      if (!hv[1]) begin
        mode_next  = MODE_IDLE;
        lines_next = 2'b11;
      end
    end
  end

  assign res_data = {lines_next[0], lines_next[1], irq_next,
                     host_ctrl_next[1] & lines_next[1], host_ctrl_next & lines_next};

  ps2kt_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (PTR_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push_ok),
    .wr_addr (tail),
    .wr_data (push_byte),
    .rd_addr (head_next),
    .rd_data (ring_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      mode       <= MODE_IDLE;
      shift_byte <= 8'd0;
      bit_index  <= 4'd0;
      tick_count <= 17'sd0;
      parity     <= 1'b0;
      lines      <= 2'b11;
      host_ctrl  <= 2'b11;
      pend_cnt   <= 2'd0;
      pend_tick  <= 1'b0;
    end else begin
      head       <= head_next;
      tail       <= tail_next;
      mode       <= mode_next;
      shift_byte <= shift_byte_next;
      bit_index  <= bit_index_next;
      tick_count <= tick_count_next;
      parity     <= parity_next;
      lines      <= lines_next;
      host_ctrl  <= host_ctrl_next;
      pend_cnt   <= pend_cnt_next;
      pend_tick  <= pend_tick_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_b0 <= pend_b0_next;
    pend_b1 <= pend_b1_next;
  end

  // output register plus skid stage
  assign out_pop = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || out_pop) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= produce;
      end else begin
        m_tvalid   <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || out_pop) begin
      out_data <= skid_valid ? skid_data : res_data;
      if (skid_valid) begin
        skid_data <= res_data;
      end
    end else if (produce) begin
      skid_data <= res_data;
    end
  end

  assign m_tdata = {2'b00, out_data};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid stage holds a transaction while output register is empty");

  a_irq_on_fall: assert property (@(posedge clk) disable iff (rst)
    (do_tick && irq_next) |-> (!lines_next[1] && (mode_next == MODE_SEND)))
    else $error("interrupt pulse without a falling clock during a frame");

  a_pop_moves_head: assert property (@(posedge clk) disable iff (rst)
    ((mode == MODE_SEND) && ($past(mode) == MODE_IDLE)) |-> (head != $past(head)))
    else $error("frame started without popping the ring");

endmodule

[rtl/ps2kt_ring.sv]
// Byte ring storage: one write port, one registered read port with write forwarding.
module ps2kt_ring
  import ps2kt_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  byte_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output byte_t         rd_data
);

  byte_t mem [DEPTH];
  byte_t rd_q;
  byte_t fwd_data;
  logic  fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q     <= mem[rd_addr];
    fwd_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule
